// ----- rtl/pose_integrator_rk2_macros.svh -----
// Assertion macros shared by the checker.
`ifndef POSE_INTEGRATOR_RK2_MACROS_SVH
`define POSE_INTEGRATOR_RK2_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define PIR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pose_integrator_rk2 check failed");

// Next-cycle implication checked outside reset.
`define PIR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pose_integrator_rk2 check failed");

`endif

// ----- rtl/pir_pkg.sv -----
package pir_pkg;

  localparam int CordicSteps = 16;
  localparam int TableLen    = 24;
  localparam int StepsUsed   = (CordicSteps < TableLen) ? CordicSteps : TableLen;
  localparam int StepW       = $clog2(StepsUsed + 1);

  localparam logic signed [47:0] PosMax = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] PosMin = 48'sh8000_0000_0000;
  localparam logic signed [33:0] GainStart = 34'sd652032874;

  // ceil(2^32 / 125): exact floor(x / 125) for 0 <= x < 2^25 via (x * Recip125) >> 32.
  localparam logic [25:0] Recip125 = 26'd34359739;
  // 125 * 67109, lifts any signed 24-bit yaw rate above zero before the reciprocal.
  localparam logic [24:0] YawLift  = 25'd8388625;
  localparam logic [18:0] YawLiftQ = 19'd67109;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PROD,
    ST_DIV,
    ST_FRAC,
    ST_FOLD,
    ST_SETUP,
    ST_CORDIC,
    ST_ROUND,
    ST_MUL_A,
    ST_MUL_B,
    ST_SCALE,
    ST_UPDATE,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic load;
    logic prod;
    logic div;
    logic frac;
    logic fold;
    logic setup;
    logic iter;
    logic round;
    logic mul_a;
    logic mul_b;
    logic scale;
    logic update;
  } dp_cmd_t;

  typedef struct packed {
    logic last_step;
  } dp_stat_t;

  function automatic logic signed [33:0] atan_turns(input logic [4:0] i);
    logic signed [33:0] v;
    case (i)
      5'd0:  v = 34'sd536870912;
      5'd1:  v = 34'sd316933406;
      5'd2:  v = 34'sd167458907;
      5'd3:  v = 34'sd85004756;
      5'd4:  v = 34'sd42667331;
      5'd5:  v = 34'sd21354465;
      5'd6:  v = 34'sd10679838;
      5'd7:  v = 34'sd5340245;
      5'd8:  v = 34'sd2670163;
      5'd9:  v = 34'sd1335087;
      5'd10: v = 34'sd667544;
      5'd11: v = 34'sd333772;
      5'd12: v = 34'sd166886;
      5'd13: v = 34'sd83443;
      5'd14: v = 34'sd41722;
      5'd15: v = 34'sd20861;
      5'd16: v = 34'sd10430;
      5'd17: v = 34'sd5215;
      5'd18: v = 34'sd2608;
      5'd19: v = 34'sd1304;
      5'd20: v = 34'sd652;
      5'd21: v = 34'sd326;
      5'd22: v = 34'sd163;
      5'd23: v = 34'sd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/pir_ctrl.sv -----
module pir_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  pir_pkg::dp_stat_t stat_i,
  output pir_pkg::dp_cmd_t  cmd_o
);

  pir_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pir_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      pir_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = pir_pkg::ST_PROD;
        end
      end
      pir_pkg::ST_PROD: begin
        cmd_o.prod = 1'b1;
        state_d    = pir_pkg::ST_DIV;
      end
      pir_pkg::ST_DIV: begin
        cmd_o.div = 1'b1;
        state_d   = pir_pkg::ST_FRAC;
      end
      pir_pkg::ST_FRAC: begin
        cmd_o.frac = 1'b1;
        state_d    = pir_pkg::ST_FOLD;
      end
      pir_pkg::ST_FOLD: begin
        cmd_o.fold = 1'b1;
        state_d    = pir_pkg::ST_SETUP;
      end
      pir_pkg::ST_SETUP: begin
        cmd_o.setup = 1'b1;
        state_d     = pir_pkg::ST_CORDIC;
      end
      pir_pkg::ST_CORDIC: begin
        cmd_o.iter = 1'b1;
        if (stat_i.last_step) state_d = pir_pkg::ST_ROUND;
      end
      pir_pkg::ST_ROUND: begin
        cmd_o.round = 1'b1;
        state_d     = pir_pkg::ST_MUL_A;
      end
      pir_pkg::ST_MUL_A: begin
        cmd_o.mul_a = 1'b1;
        state_d     = pir_pkg::ST_MUL_B;
      end
      pir_pkg::ST_MUL_B: begin
        cmd_o.mul_b = 1'b1;
        state_d     = pir_pkg::ST_SCALE;
      end
      pir_pkg::ST_SCALE: begin
        cmd_o.scale = 1'b1;
        state_d     = pir_pkg::ST_UPDATE;
      end
      pir_pkg::ST_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = pir_pkg::ST_OUT;
      end
      pir_pkg::ST_OUT: begin
        out_valid_o = 1'b1;
        // Output register holds the pose, so take the next item with the handoff.
        if (out_ready_i) begin
          in_ready_o = 1'b1;
          if (in_valid_i) begin
            cmd_o.load = 1'b1;
            state_d    = pir_pkg::ST_PROD;
          end else begin
            state_d = pir_pkg::ST_IDLE;
          end
        end
      end
      default: state_d = pir_pkg::ST_IDLE;
    endcase
  end

endmodule

// ----- rtl/pir_datapath.sv -----
module pir_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic signed [15:0]  vel_forward_i,
  input  logic signed [15:0]  vel_lateral_i,
  input  logic signed [23:0]  yaw_rate_i,
  input  logic [15:0]         elapsed_ms_i,
  input  pir_pkg::dp_cmd_t    cmd_i,
  output pir_pkg::dp_stat_t   stat_o,
  output logic signed [47:0]  pos_x_o,
  output logic signed [47:0]  pos_y_o,
  output logic [31:0]         heading_angle_o
);

  logic signed [15:0] vx_q, vy_q;
  logic signed [23:0] w_q;
  logic [15:0]        ms_q;
  logic signed [17:0] wq_q;
  logic [22:0]        u_q;
  logic [31:0]        wm_q;
  logic [16:0]        uq_q;
  logic [31:0]        full_q, half_q;
  logic [1:0]         quad_q;
  logic signed [33:0] cx_q, cy_q, cz_q;
  logic [pir_pkg::StepW-1:0] step_q;
  logic signed [15:0] cos_q, sin_q;
  logic signed [31:0] ta_q, tb_q, tc_q, td_q;
  logic signed [33:0] sx_q, sy_q;
  logic signed [50:0] dx_q, dy_q;
  logic signed [47:0] px_q, py_q;
  logic [31:0]        hd_q;

  // Heading increments floor(w*ms*512/125) and floor(w*ms*256/125), split as
  // w = 125*wq + wr and wr*ms = 125*uq + ur, each quotient by reciprocal multiply.
  logic [24:0]        w_lift;
  logic [50:0]        w_scaled;
  logic [18:0]        wq_diff;
  logic signed [25:0] wq_x125, wr_full;
  logic [6:0]         wr;
  logic signed [34:0] wm_prod;
  logic [48:0]        u_scaled;
  logic [22:0]        uq_x125, ur_full;
  logic [6:0]         ur;
  logic [32:0]        ur_scaled;
  logic [9:0]         fq;
  logic [8:0]         hq;
  always_comb begin
    w_lift    = 25'(w_q) + pir_pkg::YawLift;
    w_scaled  = 51'(w_lift) * 51'(pir_pkg::Recip125);
    wq_diff   = w_scaled[50:32] - pir_pkg::YawLiftQ;
    wq_x125   = 26'(wq_q) * 26'sd125;
    wr_full   = 26'(w_q) - wq_x125;
    wr        = wr_full[6:0];
    wm_prod   = 35'(wq_q) * $signed({1'b0, ms_q});
    u_scaled  = 49'(u_q) * 49'(pir_pkg::Recip125);
    uq_x125   = 23'(uq_q) * 23'd125;
    ur_full   = u_q - uq_x125;
    ur        = ur_full[6:0];
    ur_scaled = 33'(ur) * 33'(pir_pkg::Recip125);
    fq        = ur_scaled[32:23];
    hq        = ur_scaled[32:24];
  end

  // Quadrant reduction.
  logic [31:0] mid, mshift;
  logic [1:0]  k;
  logic signed [33:0] z0;
  always_comb begin
    mid    = hd_q + half_q;
    mshift = mid + 32'h2000_0000;
    k      = mshift[31:30];
    z0     = $signed({2'b00, mid}) - $signed({2'b00, k, 30'd0});
    if (z0 >= 34'sh0_8000_0000) z0 = z0 - 34'sh1_0000_0000;
  end

  logic signed [33:0] xs, ys, at;
  logic [4:0] tidx;
  assign tidx = 5'(step_q);
  assign xs   = cx_q >>> step_q;
  assign ys   = cy_q >>> step_q;
  assign at   = pir_pkg::atan_turns(tidx);
  assign stat_o.last_step = (step_q == pir_pkg::StepW'(pir_pkg::StepsUsed - 1));

  function automatic logic signed [15:0] to_q15(input logic signed [33:0] v);
    logic signed [34:0] r;
    r = (35'(v) + 35'sd16384) >>> 15;
    if (r > 35'sd32767) return 16'sh7FFF;
    if (r < -35'sd32768) return 16'sh8000;
    return r[15:0];
  endfunction

  logic signed [15:0] c, s, cr, sr;
  always_comb begin
    c = to_q15(cx_q);
    s = to_q15(cy_q);
    case (quad_q)
      2'd0:    begin cr = c;  sr = s;  end
      2'd1:    begin cr = -s; sr = c;  end
      2'd2:    begin cr = -c; sr = -s; end
      default: begin cr = s;  sr = -c; end
    endcase
  end

  function automatic logic signed [47:0] sat48(input logic signed [51:0] v);
    if (v > 52'(pir_pkg::PosMax)) return pir_pkg::PosMax;
    if (v < 52'(pir_pkg::PosMin)) return pir_pkg::PosMin;
    return v[47:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      px_q <= '0;
      py_q <= '0;
      hd_q <= '0;
    end else if (cmd_i.update) begin
      px_q <= sat48(52'(px_q) + 52'(dx_q));
      py_q <= sat48(52'(py_q) + 52'(dy_q));
      hd_q <= hd_q + full_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      vx_q <= vel_forward_i;
      vy_q <= vel_lateral_i;
      w_q  <= yaw_rate_i;
      ms_q <= elapsed_ms_i;
    end
    if (cmd_i.prod) wq_q <= wq_diff[17:0];
    if (cmd_i.div) begin
      u_q  <= 23'(wr) * 23'(ms_q);
      wm_q <= wm_prod[31:0];
    end
    if (cmd_i.frac) uq_q <= u_scaled[48:32];
    if (cmd_i.fold) begin
      full_q <= (wm_q << 9) + (32'(uq_q) << 9) + 32'(fq);
      half_q <= (wm_q << 8) + (32'(uq_q) << 8) + 32'(hq);
    end
    if (cmd_i.setup) begin
      quad_q <= k;
      cx_q   <= pir_pkg::GainStart;
      cy_q   <= '0;
      cz_q   <= z0;
      step_q <= '0;
    end
    if (cmd_i.iter) begin
      if (cz_q >= 0) begin
        cx_q <= cx_q - ys; cy_q <= cy_q + xs; cz_q <= cz_q - at;
      end else begin
        cx_q <= cx_q + ys; cy_q <= cy_q - xs; cz_q <= cz_q + at;
      end
      step_q <= step_q + 1'b1;
    end
    if (cmd_i.round) begin
      cos_q <= cr;
      sin_q <= sr;
    end
    if (cmd_i.mul_a) begin
      ta_q <= vx_q * cos_q;
      tb_q <= vy_q * sin_q;
      tc_q <= vx_q * sin_q;
      td_q <= vy_q * cos_q;
    end
    if (cmd_i.mul_b) begin
      sx_q <= 34'(ta_q) - 34'(tb_q);
      sy_q <= 34'(tc_q) + 34'(td_q);
    end
    if (cmd_i.scale) begin
      dx_q <= 51'((51'(sx_q) * $signed({1'b0, ms_q})) >>> 15);
      dy_q <= 51'((51'(sy_q) * $signed({1'b0, ms_q})) >>> 15);
    end
  end

  assign pos_x_o         = px_q;
  assign pos_y_o         = py_q;
  assign heading_angle_o = hd_q;

endmodule

// ----- rtl/pose_integrator_rk2.sv -----
// Channel   Dir  Payload (tdata, low bit first)
// s_axis    in   vel_forward[15:0] vel_lateral[31:16] yaw_rate[55:32] elapsed_ms[71:56]
// m_axis    out  pos_x[47:0] pos_y[95:48] heading_angle[127:96]
// From the input transaction to tvalid an item passes through the heading increment
// states (product, divide, fraction, fold), a setup state, the CORDIC steps at
// one step per cycle, then round, two multiplies, scale and update.
// Reset clears the pose to zero and the controller to idle.
// A stalled result holds in the output register; the next input is
// taken in the same cycle the result is taken.
module pose_integrator_rk2 (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [71:0]  s_axis_tdata,   // vel_forward, vel_lateral, yaw_rate, elapsed_ms
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata    // pos_x, pos_y, heading_angle
);

  pir_pkg::dp_cmd_t  cmd;
  pir_pkg::dp_stat_t stat;
  logic signed [47:0] pos_x, pos_y;
  logic [31:0]        heading;

  // Sequence the item through increments, CORDIC, multiply and update.
  pir_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  pir_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .vel_forward_i   (s_axis_tdata[15:0]),
    .vel_lateral_i   (s_axis_tdata[31:16]),
    .yaw_rate_i      (s_axis_tdata[55:32]),
    .elapsed_ms_i    (s_axis_tdata[71:56]),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .pos_x_o         (pos_x),
    .pos_y_o         (pos_y),
    .heading_angle_o (heading)
  );

  assign m_axis_tdata = {heading, pos_y, pos_x};

endmodule

// ----- rtl/pir_checker.sv -----
`include "pose_integrator_rk2_macros.svh"
module pir_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [127:0] m_axis_tdata
);

  `PIR_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
  `PIR_ASSERT_NEXT(a_accept_no_out, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !m_axis_tvalid)
  `PIR_ASSERT_IMPL(a_busy_no_ready, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, !s_axis_tready)

endmodule

bind pose_integrator_rk2 pir_checker u_pir_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
